// ----- rtl/whai_pkg.sv -----
// ----------------------------------------------------------------------------
// whai_pkg
// Shared widths, register indexes, constants and sequencer states for the
// windowed activity detector.
// ----------------------------------------------------------------------------
`default_nettype none

package whai_pkg;

    // Field widths of the request and result channels.
    localparam int TIME_W     = 48;
    localparam int THR_W      = 17;
    localparam int WIN_W      = 24;
    localparam int OUT_CNT_W  = 9;

    // Configuration channel.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THR  = 2'd0,
        CFG_OFF_THR = 2'd1,
        CFG_WINDOW  = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_index_t;

    // Q1.16 value of 1.0 and reset values of the registers.
    localparam logic [THR_W-1:0] Q16_ONE       = 17'h10000;
    localparam logic [THR_W-1:0] THR_RESET     = 17'h08000;
    localparam logic [WIN_W-1:0] WINDOW_RESET  = 24'd1000;
    localparam logic [WIN_W-1:0] WINDOW_MIN    = 24'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT_RD,
        S_EVICT,
        S_WRITE,
        S_DROP_RD,
        S_DROP_CHK,
        S_MUL,
        S_DEC
    } whai_state_t;

endpackage : whai_pkg

`default_nettype wire

// ----- rtl/whai_sample_if.sv -----
// ----------------------------------------------------------------------------
// whai_sample_if
// Request channel carrying one timestamped activity sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface whai_sample_if
    import whai_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] sample_time;
    logic              is_active;

    modport source (output valid, output sample_time, output is_active, input ready);
    modport sink   (input valid, input sample_time, input is_active, output ready);
endinterface : whai_sample_if

`default_nettype wire

// ----- rtl/whai_result_if.sv -----
// ----------------------------------------------------------------------------
// whai_result_if
// Result channel carrying the detector state and window occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface whai_result_if
    import whai_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 active_state;
    logic                 state_changed;
    logic [OUT_CNT_W-1:0] samples_in_window;
    logic [OUT_CNT_W-1:0] active_in_window;

    modport source (
        output valid, output active_state, output state_changed,
        output samples_in_window, output active_in_window, input ready
    );
    modport sink (
        input valid, input active_state, input state_changed,
        input samples_in_window, input active_in_window, output ready
    );
endinterface : whai_result_if

`default_nettype wire

// ----- rtl/whai_cfg_if.sv -----
// ----------------------------------------------------------------------------
// whai_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface whai_cfg_if
    import whai_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : whai_cfg_if

`default_nettype wire

// ----- rtl/windowed_activity_hysteresis.sv -----
// Sequence: a full ring first evicts its oldest entry; the request is then
// written, old entries are aged out, the product is formed and decided on.
// Throughput: one request at a time; each aging check is a ring read plus a
// compare, and the threshold product comes from one shared multiplier.
// Reset: counters, ring head, detector state and registers return to their
// defaults at once; ring contents stay undefined and are never read unwritten.
// ----------------------------------------------------------------------------
// windowed_activity_hysteresis
// Sliding time window duty detector with hysteresis, run by a small sequencer
// over one ring memory port and one threshold multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_activity_hysteresis
    import whai_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  wire               clk,
    input  wire               rst_n,
    whai_sample_if.sink       sample,
    whai_result_if.source     result,
    whai_cfg_if.sink          cfg
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = THR_W + CW;
    localparam int EW = TIME_W + 1;

    // Configuration registers.
    logic [THR_W-1:0] on_thr_reg;
    logic [THR_W-1:0] off_thr_reg;
    logic [WIN_W-1:0] window_reg;

    // Window state.
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] active_reg, active_next;
    logic          on_reg;

    // Sequencer.
    whai_state_t state_reg, state_next;

    // Latched request and arithmetic results.
    logic [TIME_W-1:0] now_reg;
    logic              act_reg;
    logic [PW-1:0]     prod_reg;

    // Result register.
    logic                 res_valid_reg;
    logic                 res_state_reg;
    logic                 res_changed_reg;
    logic [OUT_CNT_W-1:0] res_samples_reg;
    logic [OUT_CNT_W-1:0] res_active_reg;

    // Ring memory, entries are {active, time}.
    logic [EW-1:0] ring_mem [RING_DEPTH];
    logic [EW-1:0] ring_q;

    // Control strobes.
    logic mem_rd;
    logic mem_we;
    logic dec_go;

    // Derived conditions.
    logic          full;
    logic          too_old;
    logic [CW:0]   slot_sum;
    logic [IW-1:0] slot;
    logic [IW-1:0] head_inc;
    logic [PW-1:0] lhs;
    logic [THR_W-1:0] thr_sel;
    logic          cfg_hit;
    logic [THR_W-1:0] cfg_thr;
    logic [WIN_W-1:0] cfg_win;

    assign full     = (count_reg == CW'(RING_DEPTH));
    assign head_inc = (head_reg == IW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign slot_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign slot     = (slot_sum >= (CW + 1)'(RING_DEPTH))
                    ? IW'(slot_sum - (CW + 1)'(RING_DEPTH)) : IW'(slot_sum);

    // The oldest entry has aged out when its time plus the window is still
    // before the new timestamp.
    assign too_old = ({1'b0, ring_q[TIME_W-1:0]} + (TIME_W + 1)'(window_reg))
                   < {1'b0, now_reg};

    // Only the threshold for leaving the current state matters.
    assign thr_sel = on_reg ? off_thr_reg : on_thr_reg;
    assign lhs     = PW'({active_reg, 16'h0000});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                    state_next = full ? S_EVICT_RD : S_WRITE;
            end
            S_EVICT_RD: state_next = S_EVICT;
            S_EVICT:    state_next = S_WRITE;
            S_WRITE:    state_next = S_DROP_RD;
            S_DROP_RD:  state_next = S_DROP_CHK;
            S_DROP_CHK: state_next = too_old ? S_DROP_RD : S_MUL;
            S_MUL:      state_next = S_DEC;
            S_DEC:
            begin
                if (!res_valid_reg || result.ready)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        sample.ready = (state_reg == S_IDLE);
        mem_rd       = (state_reg == S_EVICT_RD) || (state_reg == S_DROP_RD);
        mem_we       = (state_reg == S_WRITE);
        dec_go       = (state_reg == S_DEC) && (!res_valid_reg || result.ready);
    end

    // Window counters: eviction, append and aging.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        active_next = active_reg;
        if (state_reg == S_EVICT || (state_reg == S_DROP_CHK && too_old))
        begin
            head_next  = head_inc;
            count_next = count_reg - 1'b1;
            if (ring_q[TIME_W] && active_reg != '0)
                active_next = active_reg - 1'b1;
        end
        else if (mem_we)
        begin
            count_next  = count_reg + 1'b1;
            active_next = active_reg + CW'(act_reg);
        end
    end

    // Ring memory port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[slot] <= {act_reg, now_reg};
        if (mem_rd)
            ring_q <= ring_mem[head_reg];
    end

    // Configuration write decode with clamping.
    assign cfg.ready = 1'b1;
    assign cfg_hit   = cfg.valid;
    assign cfg_thr   = (cfg.data[THR_W-1:0] > Q16_ONE) ? Q16_ONE : cfg.data[THR_W-1:0];
    assign cfg_win   = (cfg.data[WIN_W-1:0] == '0) ? WINDOW_MIN : cfg.data[WIN_W-1:0];

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            active_reg    <= '0;
            on_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
            on_thr_reg    <= THR_RESET;
            off_thr_reg   <= THR_RESET;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            active_reg <= active_next;

            if (cfg_hit)
            begin
                unique case (cfg_index_t'(cfg.index))
                    CFG_ON_THR:  on_thr_reg  <= cfg_thr;
                    CFG_OFF_THR: off_thr_reg <= cfg_thr;
                    CFG_WINDOW:  window_reg  <= cfg_win;
                    CFG_NONE:    ;
                    default:     ;
                endcase
            end

            // Hysteresis decision loads the result register.
            if (dec_go)
            begin
                res_valid_reg <= 1'b1;
                if (!on_reg && lhs >= prod_reg)
                    on_reg <= 1'b1;
                else if (on_reg && lhs < prod_reg)
                    on_reg <= 1'b0;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            now_reg <= sample.sample_time;
            act_reg <= sample.is_active;
        end
        if (state_reg == S_MUL)
            prod_reg <= PW'(thr_sel) * PW'(count_reg);
        if (dec_go)
        begin
            res_changed_reg <= on_reg ? (lhs < prod_reg) : (lhs >= prod_reg);
            res_state_reg   <= on_reg ? !(lhs < prod_reg) : (lhs >= prod_reg);
            res_samples_reg <= OUT_CNT_W'(count_reg);
            res_active_reg  <= OUT_CNT_W'(active_reg);
        end
    end

    assign result.valid             = res_valid_reg;
    assign result.active_state      = res_state_reg;
    assign result.state_changed     = res_changed_reg;
    assign result.samples_in_window = res_samples_reg;
    assign result.active_in_window  = res_active_reg;

endmodule : windowed_activity_hysteresis

`default_nettype wire

// ----- test/tb_windowed_activity_hysteresis.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_activity_hysteresis
// Self-checking bench for the sliding time window duty detector. It drives
// timestamped activity samples and register writes through their valid/ready
// channels, keeps its own copy of the window ring and detector state to work
// out each expected report, and checks every report field by field.
// ----------------------------------------------------------------------------

module tb_windowed_activity_hysteresis;
    timeunit 1ns;
    timeprecision 1ps;

    import whai_pkg::*;

    localparam int DEPTH      = 256;
    localparam int RUN_LIMIT  = 2_000_000;
    localparam int SETTLE     = 40;
    localparam int REPORT_MAX = 10;
    localparam int HOLD_LONG  = 400;

    // Q0.16 fractions used as working thresholds.
    localparam logic [CFG_DATA_W-1:0] FRAC_40 = 24'd26214;
    localparam logic [CFG_DATA_W-1:0] FRAC_60 = 24'd39322;
    localparam logic [CFG_DATA_W-1:0] FRAC_70 = 24'd45875;

    typedef struct packed {
        logic                 active_state;
        logic                 state_changed;
        logic [OUT_CNT_W-1:0] samples_in_window;
        logic [OUT_CNT_W-1:0] active_in_window;
    } detect_report_t;

    logic clk = 1'b0;
    logic rst_n;

    whai_sample_if sample_ch ();
    whai_result_if result_ch ();
    whai_cfg_if    cfg_ch ();

    windowed_activity_hysteresis #(
        .RING_DEPTH (DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Our copy of the detector registers and window ring.
    logic [THR_W-1:0]  on_thr  = THR_RESET;
    logic [THR_W-1:0]  off_thr = THR_RESET;
    logic [WIN_W-1:0]  win_len = WINDOW_RESET;
    logic [TIME_W-1:0] hist_time [DEPTH];
    logic              hist_act  [DEPTH];
    int unsigned       hist_head   = 0;
    int unsigned       hist_count  = 0;
    int unsigned       hist_active = 0;
    logic              det_on      = 1'b0;

    detect_report_t pending_reports [$];

    int unsigned mismatches      = 0;
    int unsigned reports_checked = 0;
    int unsigned samples_sent    = 0;
    int unsigned reg_writes      = 0;
    int unsigned peak_fill       = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct   = 7;
    int unsigned recv_idle_pct   = 83;
    int unsigned hold_left       = 0;
    logic [TIME_W-1:0] now_ms    = '0;

    // Clock: 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Drop the oldest ring entry and uncount its activity.
    function automatic void retire_oldest();
        if (hist_count == 0)
        begin
            return;
        end
        if (hist_act[hist_head] && hist_active > 0)
        begin
            hist_active--;
        end
        hist_head = (hist_head + 1) % DEPTH;
        hist_count--;
    endfunction

    // Evict if full, append one sample, age out old entries, apply hysteresis, queue the report.
    function automatic void advance_window(input logic [TIME_W-1:0] t, input logic act);
        int unsigned     slot;
        longint unsigned weighted;
        longint unsigned on_level;
        longint unsigned off_level;
        detect_report_t  rep;
        if (hist_count >= DEPTH)
        begin
            retire_oldest();
        end
        slot = (hist_head + hist_count) % DEPTH;
        hist_time[slot] = t;
        hist_act[slot]  = act;
        hist_count++;
        if (act)
        begin
            hist_active++;
        end

        // Only the oldest entry is tested, so older samples behind it may stay.
        while (hist_count > 0 && 64'(hist_time[hist_head]) + 64'(win_len) < 64'(t))
        begin
            retire_oldest();
        end

        weighted  = 64'(hist_active) * 64'(Q16_ONE);
        on_level  = 64'(on_thr) * 64'(hist_count);
        off_level = 64'(off_thr) * 64'(hist_count);
        rep.state_changed = 1'b0;
        if (hist_count > 0)
        begin
            if (!det_on && weighted >= on_level)
            begin
                det_on = 1'b1;
                rep.state_changed = 1'b1;
            end
            else if (det_on && weighted < off_level)
            begin
                det_on = 1'b0;
                rep.state_changed = 1'b1;
            end
        end
        rep.active_state      = det_on;
        rep.samples_in_window = OUT_CNT_W'(hist_count);
        rep.active_in_window  = OUT_CNT_W'(hist_active);
        pending_reports.push_back(rep);
        if (hist_count > peak_fill)
        begin
            peak_fill = hist_count;
        end
    endfunction

    // Register write: thresholds are masked to 17 bits and clamped to 1.0,
    // a zero window becomes one, and the spare index is ignored.
    function automatic void apply_register(input cfg_index_t idx,
                                           input logic [CFG_DATA_W-1:0] value);
        logic [THR_W-1:0] thr;
        thr = value[THR_W-1:0];
        if (thr > Q16_ONE)
        begin
            thr = Q16_ONE;
        end
        case (idx)
            CFG_ON_THR:  on_thr  = thr;
            CFG_OFF_THR: off_thr = thr;
            CFG_WINDOW:  win_len = (value == '0) ? WINDOW_MIN : value[WIN_W-1:0];
            default:     ;
        endcase
    endfunction

    // Move the sample clock on: mostly small steps, with repeats, steps back
    // in time and gaps much longer than any window.
    function automatic void step_clock(input int unsigned span);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10 && now_ms > span)
        begin
            now_ms = now_ms - $urandom_range(span, 1);
        end
        else if (pick < 16)
        begin
            now_ms = now_ms + $urandom_range(32'h0200_0000, 1);
        end
        else if (pick < 90)
        begin
            now_ms = now_ms + $urandom_range(span);
        end
    endfunction

    // Threshold write data: mostly legal fractions, sometimes any 24-bit value.
    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        if ($urandom_range(3) == 0)
        begin
            return CFG_DATA_W'($urandom());
        end
        return CFG_DATA_W'($urandom_range(65536));
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            note_mismatch($sformatf("report %0d %s: expected %0d, got %0d",
                                    reports_checked, name, want, got));
        end
    endtask

    // Send one sample request; valid stays up after acceptance until the next
    // call or sample_idle decides at the following falling edge.
    task automatic send_sample(input logic [TIME_W-1:0] t, input logic act);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample_time <= t;
        sample_ch.is_active   <= act;
        do
        begin
            @(posedge clk);
        end
        while (!sample_ch.ready);
        samples_sent++;
        advance_window(t, act);
    endtask

    task automatic sample_idle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
    endtask

    // Hold new requests until every expected report has come back.
    task automatic wait_for_reports();
        sample_idle();
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        reg_writes++;
        apply_register(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset settings; early timestamps and the exact window boundary.
    task automatic test_reset_defaults();
        send_sample(48'd0, 1'b1);      // full fraction turns on
        send_sample(48'd5, 1'b0);      // exactly one half holds
        send_sample(48'd10, 1'b0);     // below one half turns off
        send_sample(48'd1000, 1'b1);   // oldest sits exactly one window back
        send_sample(48'd1001, 1'b1);   // oldest falls out of the window
        send_sample(48'd5000, 1'b1);   // long gap ages out everything else
        wait_for_reports();
    endtask

    // Threshold clamping and masking, minimum window, ignored register index.
    task automatic test_register_limits();
        write_reg(CFG_ON_THR, 24'hFFFFFF);
        write_reg(CFG_OFF_THR, 24'h000000);
        write_reg(CFG_WINDOW, 24'h000000);
        send_sample(48'd5100, 1'b1);
        send_sample(48'd5101, 1'b1);
        send_sample(48'd5101, 1'b0);
        wait_for_reports();

        write_reg(CFG_OFF_THR, 24'h010000);
        write_reg(CFG_NONE, 24'hABCDEF);
        send_sample(48'd5102, 1'b1);   // two thirds active falls below 1.0
        send_sample(48'd5200, 1'b1);   // a lone active sample reaches 1.0
        wait_for_reports();

        write_reg(CFG_ON_THR, 24'h020005);
        write_reg(CFG_OFF_THR, 24'h000005);
        send_sample(48'd5200, 1'b0);
        send_sample(48'd5300, 1'b0);
        wait_for_reports();

        write_reg(CFG_ON_THR, 24'h000000);
        write_reg(CFG_OFF_THR, 24'h000000);
        send_sample(48'd5400, 1'b0);   // zero threshold turns on with nothing active
        wait_for_reports();
    endtask

    // Widest window, timestamps at both ends of the range and going backward.
    task automatic test_time_extremes();
        write_reg(CFG_WINDOW, 24'hFFFFFF);
        send_sample(48'h5555_5555_5555, 1'b0);
        send_sample(48'h0000_0000_0000, 1'b1);
        send_sample(48'hAAAA_AAAA_AAAA, 1'b1);
        send_sample(48'hFFFF_FFFF_FFFF, 1'b0);
        send_sample(48'hFFFF_FFFF_FFFF, 1'b1);
        wait_for_reports();
    endtask

    // Fill the ring past its depth so every new sample evicts the oldest,
    // then jump far ahead so nearly the whole ring ages out at once.
    task automatic test_ring_overflow();
        int unsigned act_pct;
        act_pct = 50;
        write_reg(CFG_ON_THR, FRAC_60);
        write_reg(CFG_OFF_THR, FRAC_40);
        now_ms = '0;
        for (int i = 0; i < 290; i++)
        begin
            if (i % 48 == 0)
            begin
                case ($urandom_range(2))
                    0:       act_pct = 10;
                    1:       act_pct = 50;
                    default: act_pct = 90;
                endcase
            end
            now_ms = now_ms + $urandom_range(3);
            send_sample(now_ms, $urandom_range(99) < act_pct);
        end
        now_ms = now_ms + 48'h0200_0000;
        send_sample(now_ms, 1'b1);
        wait_for_reports();
    endtask

    // Several rounds of random thresholds and window lengths.
    task automatic test_random_windows();
        int unsigned win;
        int unsigned act_pct;
        send_idle_pct = 83;
        recv_idle_pct = 7;
        for (int round = 0; round < 4; round++)
        begin
            case (round)
                0:       win = 1;
                1:       win = $urandom_range(8, 2);
                2:       win = $urandom_range(300, 20);
                default: win = $urandom_range(5000, 1000);
            endcase
            write_reg(CFG_ON_THR, pick_threshold());
            write_reg(CFG_OFF_THR, pick_threshold());
            write_reg(CFG_WINDOW, CFG_DATA_W'(win));
            act_pct = $urandom_range(90, 10);
            repeat (40)
            begin
                step_clock(win / 8 + 2);
                send_sample(now_ms, $urandom_range(99) < act_pct);
            end
            wait_for_reports();
        end
    endtask

    // Long result stall with the sender still offering, a full pause of the
    // sender, then a burst with no idling on either side.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_ON_THR, FRAC_70);
        write_reg(CFG_OFF_THR, FRAC_40);
        write_reg(CFG_WINDOW, 24'd200);
        hold_left = HOLD_LONG;
        repeat (20)
        begin
            step_clock(20);
            send_sample(now_ms, 1'($urandom_range(1)));
        end
        wait_for_reports();
        repeat (60)
        begin
            step_clock(20);
            send_sample(now_ms, $urandom_range(99) < 65);
        end
        sample_idle();
    endtask

    // Result ready: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted report against the oldest expectation.
    always @(posedge clk)
    begin : report_check
        detect_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                note_mismatch($sformatf("unexpected report: state %0b changed %0b held %0d active %0d",
                                        result_ch.active_state, result_ch.state_changed,
                                        result_ch.samples_in_window,
                                        result_ch.active_in_window));
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("active_state", want.active_state, result_ch.active_state);
                check_field("state_changed", want.state_changed, result_ch.state_changed);
                check_field("samples_in_window", want.samples_in_window,
                            result_ch.samples_in_window);
                check_field("active_in_window", want.active_in_window,
                            result_ch.active_in_window);
            end
            reports_checked++;
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d reports outstanding.",
                 cycle_count, pending_reports.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.sample_time = '0;
        sample_ch.is_active   = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_ON_THR;
        cfg_ch.data           = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_limits();
        test_time_extremes();
        test_ring_overflow();
        test_random_windows();
        test_backpressure();
        wait_for_reports();

        $display("Checked %0d reports from %0d samples and %0d register writes; peak window fill %0d.",
                 reports_checked, samples_sent, reg_writes, peak_fill);
        $display("Covered boundary and backward timestamps, ring eviction, clamped thresholds and a %0d-cycle stall.",
                 HOLD_LONG);
        if (mismatches == 0 && pending_reports.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule : tb_windowed_activity_hysteresis
